@@ sv/mma_pkg.sv @@
// ---------------------------------------------------------------------------
// mma_pkg
// Shared types and constants for the multichannel moving average block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mma_pkg;

  // Fixed field geometry
  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int MEAN_W      = SAMPLE_BITS + FRAC_BITS;
  localparam int FILL_W      = 7;
  localparam int WS_W        = 7;

  // Defaults and limits
  localparam int              WINDOW_DEPTH_DEF = 64;
  localparam int              MIN_WINDOW       = 1;
  localparam logic [WS_W-1:0] WS_RESET         = 7'd64;

  // Operation codes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // One sample per channel, channel 0 in the low slot
  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] samples_t;

  typedef struct packed {
    logic                   op;
    logic [SAMPLE_BITS-1:0] sample_ch0;
    logic [SAMPLE_BITS-1:0] sample_ch1;
    logic [SAMPLE_BITS-1:0] sample_ch2;
    logic [SAMPLE_BITS-1:0] sample_ch3;
  } in_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_ch0;
    logic [MEAN_W-1:0] mean_ch1;
    logic [MEAN_W-1:0] mean_ch2;
    logic [MEAN_W-1:0] mean_ch3;
    logic [FILL_W-1:0] fill_count;
  } out_t;

endpackage

@@ sv/mma_store.sv @@
// ---------------------------------------------------------------------------
// mma_store
// Ring store of multi-channel samples: one write port, one registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_store #(
  parameter int WINDOW_DEPTH = mma_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                               clk,
  input  logic                                               wr_en,
  input  logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] wr_addr,
  input  mma_pkg::samples_t                                  wr_data,
  input  logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] rd_addr,
  output mma_pkg::samples_t                                  rd_data
);

  mma_pkg::samples_t mem [WINDOW_DEPTH];
  mma_pkg::samples_t rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read every cycle; the data is registered and appears in the cycle after the address
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/mma_div.sv @@
// ---------------------------------------------------------------------------
// mma_div
// Restoring divider, one quotient bit per cycle, all channels side by side
// against one shared divisor. Produces floor((sum << FRAC_BITS) / divisor).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_div #(
  parameter int WINDOW_DEPTH = mma_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                                        clk,
  input  logic                                                        rst_n,
  input  logic                                                        start,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0]                           divisor,
  input  logic [mma_pkg::CHANNELS-1:0]
               [mma_pkg::SAMPLE_BITS+$clog2(WINDOW_DEPTH+1)-1:0]      sums,
  output logic                                                        done,
  output logic [mma_pkg::CHANNELS-1:0][mma_pkg::MEAN_W-1:0]           quot
);

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = mma_pkg::SAMPLE_BITS + CNT_W;
  localparam int QW     = mma_pkg::MEAN_W;
  localparam int STEP_W = $clog2(QW + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  div_r;
  logic [mma_pkg::CHANNELS-1:0][CNT_W-1:0] rem_r;
  logic [mma_pkg::CHANNELS-1:0][CNT_W-1:0] rem_nxt;
  logic [mma_pkg::CHANNELS-1:0][QW-1:0]    dq_r;
  logic [mma_pkg::CHANNELS-1:0][QW-1:0]    dq_nxt;
  logic [mma_pkg::CHANNELS-1:0][CNT_W:0]   trial;

  // One restoring step per lane; the dividend bits shift out of dq_r as the
  // quotient bits shift in
  always_comb begin
    for (int c = 0; c < mma_pkg::CHANNELS; c++) begin
      trial[c] = {rem_r[c], dq_r[c][QW-1]};
      if (trial[c] >= {1'b0, div_r}) begin
        rem_nxt[c] = CNT_W'(trial[c] - {1'b0, div_r});
        dq_nxt[c]  = {dq_r[c][QW-2:0], 1'b1};
      end else begin
        rem_nxt[c] = trial[c][CNT_W-1:0];
        dq_nxt[c]  = {dq_r[c][QW-2:0], 1'b0};
      end
    end
  end

  // Step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Load operands, then iterate. The high sum bits start the remainder: the
  // quotient always fits QW bits, so they are below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      for (int c = 0; c < mma_pkg::CHANNELS; c++) begin
        rem_r[c] <= sums[c][SUM_W-1:mma_pkg::SAMPLE_BITS];
        dq_r[c]  <= {sums[c][mma_pkg::SAMPLE_BITS-1:0], mma_pkg::FRAC_BITS'(0)};
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign done = done_r;
  assign quot = dq_r;

endmodule

@@ sv/multichannel_moving_average.sv @@
// ---------------------------------------------------------------------------
// multichannel_moving_average
// Sliding-window mean over the last window_size samples of four channels,
// kept in a ring store with a running sum per channel.
//
//   port group | direction | handshake          | word
//   in_*       | input     | in_valid/in_stall  | op + four samples
//   out_*      | output    | out_valid/out_stall| four 16.8 means + fill count
//   cfg_*      | input     | cfg_wr_en          | window_size
//
// An append or clear runs the update, load, divide (24 single-bit steps of
// the shared divider) and done states; in_stall is high meanwhile.
// The result sits in an output register, so a stalled result does not hold
// up the next word unless a second result is ready before the first leaves.
// A window_size write rescans the held samples through the single read port
// of the ring store, one read state and one add state per held sample.
// Reset is synchronous; the ring store needs no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichannel_moving_average #(
  parameter int WINDOW_DEPTH = mma_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mma_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mma_pkg::out_t             out_data,
  input  logic                      cfg_wr_en,
  input  logic [mma_pkg::WS_W-1:0]  cfg_wdata
);

  localparam int CHN   = mma_pkg::CHANNELS;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = mma_pkg::SAMPLE_BITS + CNT_W;
  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int ADD_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > mma_pkg::WS_W) ? CNT_W : mma_pkg::WS_W;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_UPDATE   = 7'b0000010,
    ST_LOAD     = 7'b0000100,
    ST_DIVIDE   = 7'b0001000,
    ST_DONE     = 7'b0010000,
    ST_SCAN     = 7'b0100000,
    ST_SCAN_ADD = 7'b1000000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [mma_pkg::WS_W-1:0]         window_size_r;
  logic [CNT_W-1:0]                 held_r, held_nxt;
  logic [PTR_W-1:0]                 oldest_r, oldest_nxt;
  logic [CHN-1:0][SUM_W-1:0]        sums_r, sums_nxt;
  logic [PTR_W-1:0]                 scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0]                 scan_left_r, scan_left_nxt;
  logic                             out_valid_r, out_valid_nxt;
  mma_pkg::out_t                    out_r;
  logic                             op_r;
  mma_pkg::samples_t                samp_r;
  mma_pkg::samples_t                rd_data;
  logic [PTR_W-1:0]                 rd_addr;
  logic [PTR_W-1:0]                 wr_addr;
  logic                             wr_en;
  logic [CNT_W-1:0]                 cap_cur;
  logic [CNT_W-1:0]                 cap_cfg;
  logic                             full;
  logic                             accept;
  logic                             out_load;
  logic                             div_done;
  logic [CHN-1:0][mma_pkg::MEAN_W-1:0] quot;

  // Clamp a window size to 1 .. WINDOW_DEPTH
  function automatic logic [CNT_W-1:0] clamp_cap(input logic [mma_pkg::WS_W-1:0] ws);
    logic [CMP_W-1:0] w;
    w = CMP_W'(ws);
    if (w < CMP_W'(mma_pkg::MIN_WINDOW)) w = CMP_W'(mma_pkg::MIN_WINDOW);
    if (w > CMP_W'(WINDOW_DEPTH)) w = CMP_W'(WINDOW_DEPTH);
    return CNT_W'(w);
  endfunction

  // Ring pointer advance; the sum stays below twice the depth
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] inc);
    logic [ADD_W-1:0] s;
    s = ADD_W'(ptr) + ADD_W'(inc);
    if (s >= ADD_W'(WINDOW_DEPTH)) s = s - ADD_W'(WINDOW_DEPTH);
    return PTR_W'(s);
  endfunction

  assign cap_cur  = clamp_cap(window_size_r);
  assign cap_cfg  = clamp_cap(cfg_wdata);
  assign full     = (held_r >= cap_cur);
  assign in_stall = (state_r != ST_IDLE) || cfg_wr_en;
  assign accept   = in_valid && !in_stall;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Ring store access: oldest entry while idle, scan pointer while rescanning
  assign rd_addr = (state_r == ST_SCAN) ? scan_ptr_r : oldest_r;
  assign wr_addr = wrap_add(oldest_r, held_r);
  assign wr_en   = (state_r == ST_UPDATE) && (op_r == mma_pkg::OP_APPEND);

  mma_store #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (samp_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mma_div #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == ST_LOAD),
    .divisor (held_r),
    .sums    (sums_r),
    .done    (div_done),
    .quot    (quot)
  );

  // Sequencer and window bookkeeping
  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    oldest_nxt    = oldest_r;
    sums_nxt      = sums_r;
    scan_ptr_nxt  = scan_ptr_r;
    scan_left_nxt = scan_left_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (op_r == mma_pkg::OP_CLEAR) begin
          held_nxt   = '0;
          oldest_nxt = '0;
          sums_nxt   = '0;
        end else begin
          // Drop the oldest word when the window is full, then add the new one
          for (int c = 0; c < CHN; c++) begin
            sums_nxt[c] = sums_r[c] + SUM_W'(samp_r[c])
                          - (full ? SUM_W'(rd_data[c]) : SUM_W'(0));
          end
          if (full) begin
            oldest_nxt = wrap_add(oldest_r, CNT_W'(1));
          end else begin
            held_nxt = held_r + CNT_W'(1);
          end
        end
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_left_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN_ADD;
        end
      end
      ST_SCAN_ADD: begin
        for (int c = 0; c < CHN; c++) begin
          sums_nxt[c] = sums_r[c] + SUM_W'(rd_data[c]);
        end
        scan_ptr_nxt  = wrap_add(scan_ptr_r, CNT_W'(1));
        scan_left_nxt = scan_left_r - CNT_W'(1);
        state_nxt     = ST_SCAN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Window size write: trim the oldest excess, then rebuild the sums
    if (cfg_wr_en) begin
      if (held_r > cap_cfg) begin
        oldest_nxt = wrap_add(oldest_r, held_r - cap_cfg);
        held_nxt   = cap_cfg;
      end else begin
        oldest_nxt = oldest_r;
        held_nxt   = held_r;
      end
      sums_nxt      = '0;
      scan_ptr_nxt  = oldest_nxt;
      scan_left_nxt = held_nxt;
      state_nxt     = ST_SCAN;
    end
  end

  // Output register: hold while stalled, refill from the finished division
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      window_size_r <= mma_pkg::WS_RESET;
      held_r        <= '0;
      oldest_r      <= '0;
      sums_r        <= '0;
      scan_ptr_r    <= '0;
      scan_left_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      oldest_r    <= oldest_nxt;
      sums_r      <= sums_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      scan_left_r <= scan_left_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) window_size_r <= cfg_wdata;
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_data.op;
      samp_r <= {in_data.sample_ch3, in_data.sample_ch2,
                 in_data.sample_ch1, in_data.sample_ch0};
    end
  end

  // Load the result word; an empty window reads as zero means
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.mean_ch0   <= (held_r == '0) ? '0 : quot[0];
      out_r.mean_ch1   <= (held_r == '0) ? '0 : quot[1];
      out_r.mean_ch2   <= (held_r == '0) ? '0 : quot[2];
      out_r.mean_ch3   <= (held_r == '0) ? '0 : quot[3];
      out_r.fill_count <= mma_pkg::FILL_W'(held_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_held_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= cap_cur)
    else $error("held count exceeds the effective window");

  a_accept_starts_update: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_UPDATE))
    else $error("accepted word did not enter the update step");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done step");

  a_scan_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_left_r == '0 && !cfg_wr_en) |=> (state_r == ST_IDLE))
    else $error("rescan did not return to idle");
`endif

endmodule
